/* hdl/jtpw_pkg.sv */
// jtpw_pkg: tap state codes, sequencer states and route step types
// for the tms path walker; no dependencies
`default_nettype none

package jtpw_pkg;

  localparam logic [4:0] TAP_RESET   = 5'd0;
  localparam logic [4:0] TAP_IDLE    = 5'd1;
  localparam logic [4:0] TAP_SELDR   = 5'd2;
  localparam logic [4:0] TAP_CAPDR   = 5'd3;
  localparam logic [4:0] TAP_SHDR    = 5'd4;
  localparam logic [4:0] TAP_EX1DR   = 5'd5;
  localparam logic [4:0] TAP_PADR    = 5'd6;
  localparam logic [4:0] TAP_EX2DR   = 5'd7;
  localparam logic [4:0] TAP_UPDR    = 5'd8;
  localparam logic [4:0] TAP_SELIR   = 5'd9;
  localparam logic [4:0] TAP_CAPIR   = 5'd10;
  localparam logic [4:0] TAP_SHIR    = 5'd11;
  localparam logic [4:0] TAP_EX1IR   = 5'd12;
  localparam logic [4:0] TAP_PAIR    = 5'd13;
  localparam logic [4:0] TAP_EX2IR   = 5'd14;
  localparam logic [4:0] TAP_UPIR    = 5'd15;
  localparam logic [4:0] TAP_UNKNOWN = 5'd16;

  localparam int WALK_LIMIT = 16;

  localparam logic OP_GOTO  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef enum logic [4:0] {
    SEQ_IDLE  = 5'b00001,
    SEQ_RESET = 5'b00010,
    SEQ_EXTRA = 5'b00100,
    SEQ_WALK  = 5'b01000,
    SEQ_PAD   = 5'b10000
  } seq_t;

  typedef struct packed {
    logic       tms;
    logic [3:0] nxt;
  } step_t;

endpackage

`default_nettype wire

/* hdl/jtpw_route.sv */
// jtpw_route: one step of the fixed tap route from current toward target
// depends on jtpw_pkg
`default_nettype none

module jtpw_route (
  input  wire logic [3:0]    cur,
  input  wire logic [3:0]    tgt,
  output jtpw_pkg::step_t    step
);

  logic dr_body;
  logic ir_body;

  assign dr_body = ({1'b0, tgt} >= jtpw_pkg::TAP_CAPDR) && ({1'b0, tgt} <= jtpw_pkg::TAP_UPDR);
  assign ir_body = ({1'b0, tgt} >= jtpw_pkg::TAP_CAPIR);

  function automatic jtpw_pkg::step_t mk(input logic t, input logic [4:0] s);
    jtpw_pkg::step_t r;
    r.tms = t;
    r.nxt = s[3:0];
    return r;
  endfunction

  always_comb begin
    case ({1'b0, cur})
      jtpw_pkg::TAP_RESET: step = mk(1'b0, jtpw_pkg::TAP_IDLE);
      jtpw_pkg::TAP_IDLE:  step = mk(1'b1, jtpw_pkg::TAP_SELDR);
      jtpw_pkg::TAP_SELDR: begin
        if (dr_body) step = mk(1'b0, jtpw_pkg::TAP_CAPDR);
        else step = mk(1'b1, jtpw_pkg::TAP_SELIR);
      end
      jtpw_pkg::TAP_CAPDR: begin
        if ({1'b0, tgt} == jtpw_pkg::TAP_SHDR) step = mk(1'b0, jtpw_pkg::TAP_SHDR);
        else step = mk(1'b1, jtpw_pkg::TAP_EX1DR);
      end
      jtpw_pkg::TAP_SHDR:  step = mk(1'b1, jtpw_pkg::TAP_EX1DR);
      jtpw_pkg::TAP_EX1DR: begin
        if ({1'b0, tgt} == jtpw_pkg::TAP_PADR || {1'b0, tgt} == jtpw_pkg::TAP_EX2DR ||
            {1'b0, tgt} == jtpw_pkg::TAP_SHDR)
          step = mk(1'b0, jtpw_pkg::TAP_PADR);
        else step = mk(1'b1, jtpw_pkg::TAP_UPDR);
      end
      jtpw_pkg::TAP_PADR:  step = mk(1'b1, jtpw_pkg::TAP_EX2DR);
      jtpw_pkg::TAP_EX2DR: begin
        if ({1'b0, tgt} == jtpw_pkg::TAP_SHDR || {1'b0, tgt} == jtpw_pkg::TAP_EX1DR ||
            {1'b0, tgt} == jtpw_pkg::TAP_PADR)
          step = mk(1'b0, jtpw_pkg::TAP_SHDR);
        else step = mk(1'b1, jtpw_pkg::TAP_UPDR);
      end
      jtpw_pkg::TAP_SELIR: begin
        if (ir_body) step = mk(1'b0, jtpw_pkg::TAP_CAPIR);
        else step = mk(1'b1, jtpw_pkg::TAP_RESET);
      end
      jtpw_pkg::TAP_CAPIR: begin
        if ({1'b0, tgt} == jtpw_pkg::TAP_SHIR) step = mk(1'b0, jtpw_pkg::TAP_SHIR);
        else step = mk(1'b1, jtpw_pkg::TAP_EX1IR);
      end
      jtpw_pkg::TAP_SHIR:  step = mk(1'b1, jtpw_pkg::TAP_EX1IR);
      jtpw_pkg::TAP_EX1IR: begin
        if ({1'b0, tgt} == jtpw_pkg::TAP_PAIR || {1'b0, tgt} == jtpw_pkg::TAP_EX2IR ||
            {1'b0, tgt} == jtpw_pkg::TAP_SHIR)
          step = mk(1'b0, jtpw_pkg::TAP_PAIR);
        else step = mk(1'b1, jtpw_pkg::TAP_UPIR);
      end
      jtpw_pkg::TAP_PAIR:  step = mk(1'b1, jtpw_pkg::TAP_EX2IR);
      jtpw_pkg::TAP_EX2IR: begin
        if ({1'b0, tgt} == jtpw_pkg::TAP_SHIR || {1'b0, tgt} == jtpw_pkg::TAP_EX1IR ||
            {1'b0, tgt} == jtpw_pkg::TAP_PAIR)
          step = mk(1'b0, jtpw_pkg::TAP_SHIR);
        else step = mk(1'b1, jtpw_pkg::TAP_UPIR);
      end
      default: begin
        // update-dr and update-ir
        if ({1'b0, tgt} == jtpw_pkg::TAP_IDLE) step = mk(1'b0, jtpw_pkg::TAP_IDLE);
        else step = mk(1'b1, jtpw_pkg::TAP_SELDR);
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/jtag_tap_tms_path_walker_unit.sv */
// jtag_tap_tms_path_walker_unit: top level, sequencer and output register
// depends on jtpw_pkg and jtpw_route
// an accepted request is first registered as the sequencer state, then each tms item in the output register
// throughput: one tms item per cycle while the output is not stalled; a request produces
//   route steps plus idle_count items, plus RESET_ONES+1 from unknown state, RESET_ONES for
//   a reset request, and holds the input (s_tready low) until its last item is emitted
// a request producing no item leaves the sequencer idle, so s_tready stays high
// sync reset sets the believed tap state to unknown and empties the output register
`default_nettype none

module jtag_tap_tms_path_walker_unit #(
  parameter int RESET_ONES = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [15:0] s_tdata,  // target_state[3:0], idle_count[8:4], zero
  input  wire logic       s_tuser,   // operation
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // tms[0], tap_state_after[5:1], zero
  output logic            m_tlast    // last
);

  localparam int CNT_W = (RESET_ONES > 1) ? $clog2(RESET_ONES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESET_ONES - 1);
  localparam logic [3:0] GUARD_LAST = 4'(jtpw_pkg::WALK_LIMIT - 1);

  jtpw_pkg::seq_t seq, seq_next;
  logic            op_r;
  logic [3:0]      tgt_r;
  logic [4:0]      pad_r, pad_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [3:0]      guard, guard_next;
  logic [4:0]      belief, belief_next;

  logic            tms_q, last_q;
  logic [4:0]      st_q;
  logic            emit, e_tms, e_last;
  logic [4:0]      e_st;
  logic            can_emit;
  logic            accept;
  logic            walk_done;
  jtpw_pkg::step_t step;

  jtpw_route u_route (
    .cur  (belief[3:0]),
    .tgt  (tgt_r),
    .step (step)
  );

  assign s_tready = (seq == jtpw_pkg::SEQ_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_emit = !m_tvalid || m_tready;
  assign walk_done = ({1'b0, step.nxt} == {1'b0, tgt_r}) || (guard == GUARD_LAST);

  assign m_tdata = {2'b00, st_q, tms_q};
  assign m_tlast = last_q;

  always_comb begin
    seq_next    = seq;
    pad_next    = pad_r;
    cnt_next    = cnt;
    guard_next  = guard;
    belief_next = belief;
    emit   = 1'b0;
    e_tms  = 1'b0;
    e_st   = belief;
    e_last = 1'b0;
    case (seq)
      jtpw_pkg::SEQ_IDLE: begin
        if (accept) begin
          pad_next   = s_tdata[8:4];
          cnt_next   = '0;
          guard_next = '0;
          if (s_tuser == jtpw_pkg::OP_RESET || belief > jtpw_pkg::TAP_UPIR) begin
            seq_next = jtpw_pkg::SEQ_RESET;
          end else if (belief != {1'b0, s_tdata[3:0]}) begin
            seq_next = jtpw_pkg::SEQ_WALK;
          end else if (s_tdata[8:4] != 5'd0) begin
            seq_next = jtpw_pkg::SEQ_PAD;
          end
        end
      end
      jtpw_pkg::SEQ_RESET: begin
        if (can_emit) begin
          emit  = 1'b1;
          e_tms = 1'b1;
          if (cnt == CNT_LAST) begin
            e_st        = jtpw_pkg::TAP_RESET;
            e_last      = (op_r == jtpw_pkg::OP_RESET);
            belief_next = jtpw_pkg::TAP_RESET;
            seq_next    = (op_r == jtpw_pkg::OP_RESET) ? jtpw_pkg::SEQ_IDLE
                                                       : jtpw_pkg::SEQ_EXTRA;
          end else begin
            e_st     = jtpw_pkg::TAP_UNKNOWN;
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      jtpw_pkg::SEQ_EXTRA: begin
        if (can_emit) begin
          emit        = 1'b1;
          e_tms       = 1'b1;
          e_st        = jtpw_pkg::TAP_RESET;
          belief_next = jtpw_pkg::TAP_RESET;
          if ({1'b0, tgt_r} == jtpw_pkg::TAP_RESET) begin
            e_last   = (pad_r == 5'd0);
            seq_next = (pad_r != 5'd0) ? jtpw_pkg::SEQ_PAD : jtpw_pkg::SEQ_IDLE;
          end else begin
            guard_next = '0;
            seq_next   = jtpw_pkg::SEQ_WALK;
          end
        end
      end
      jtpw_pkg::SEQ_WALK: begin
        if (can_emit) begin
          emit        = 1'b1;
          e_tms       = step.tms;
          e_st        = {1'b0, step.nxt};
          belief_next = {1'b0, step.nxt};
          guard_next  = guard + 4'd1;
          if (walk_done) begin
            e_last   = (pad_r == 5'd0);
            seq_next = (pad_r != 5'd0) ? jtpw_pkg::SEQ_PAD : jtpw_pkg::SEQ_IDLE;
          end
        end
      end
      jtpw_pkg::SEQ_PAD: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_tms    = 1'b0;
          e_st     = belief;
          e_last   = (pad_r == 5'd1);
          pad_next = pad_r - 5'd1;
          if (pad_r == 5'd1) seq_next = jtpw_pkg::SEQ_IDLE;
        end
      end
      default: begin
        seq_next = jtpw_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq      <= jtpw_pkg::SEQ_IDLE;
      belief   <= jtpw_pkg::TAP_UNKNOWN;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      guard    <= '0;
      pad_r    <= '0;
    end else begin
      seq    <= seq_next;
      belief <= belief_next;
      cnt    <= cnt_next;
      guard  <= guard_next;
      pad_r  <= pad_next;
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= s_tuser;
      tgt_r <= s_tdata[3:0];
    end
    if (emit) begin
      tms_q  <= e_tms;
      st_q   <= e_st;
      last_q <= e_last;
    end
  end

`ifndef SYNTH
  a_walk_known: assert property (@(posedge clk) disable iff (rst)
    seq == jtpw_pkg::SEQ_WALK |-> belief <= jtpw_pkg::TAP_UPIR)
    else $error("walk started from unknown tap state");

  a_reset_lands: assert property (@(posedge clk) disable iff (rst)
    (seq == jtpw_pkg::SEQ_RESET && can_emit && cnt == CNT_LAST)
    |=> (belief == jtpw_pkg::TAP_RESET && m_tvalid && m_tdata[0]))
    else $error("reset run did not land in test-logic-reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (seq == jtpw_pkg::SEQ_PAD && can_emit) |=> (m_tvalid && !m_tdata[0]))
    else $error("padding item carries tms one");

  a_unknown_tms: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5:1] == jtpw_pkg::TAP_UNKNOWN) |-> (m_tdata[0] && !m_tlast))
    else $error("unknown state item without tms one or marked last");
`endif

endmodule

`default_nettype wire
